// ----- rtl/mie_pkg.sv -----
// Package: opcodes, shared types and float compare helpers for the execute unit.
package mie_pkg;

    localparam int MEM_ADDR_WIDTH_DEF = 16;
    localparam int PC_WIDTH_DEF       = 26;
    localparam logic [4:0] LINK_REG   = 5'd28;

    typedef enum logic [5:0] {
        OP_BL   = 6'b000001,
        OP_J    = 6'b000010,
        OP_FBNE = 6'b000011,
        OP_BEQ  = 6'b000100,
        OP_BNE  = 6'b000101,
        OP_BG   = 6'b000110,
        OP_FBG  = 6'b000111,
        OP_ADDI = 6'b001000,
        OP_JAL  = 6'b011000,
        OP_LW   = 6'b100011,
        OP_LWS  = 6'b100100,
        OP_SW   = 6'b101011,
        OP_SWS  = 6'b101100,
        OP_SLL  = 6'b111111
    } t_opcode;

    typedef enum logic [1:0] {
        DK_NONE  = 2'd0,
        DK_INT   = 2'd1,
        DK_FLOAT = 2'd2,
        DK_MEM   = 2'd3
    } t_dest_kind;

    // classified instruction handed from front to back
    typedef struct packed {
        logic [31:0] ins;
        logic        supported;
    } t_decoded;

    function automatic logic f_is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic [31:0] f_key(input logic [31:0] x);
        logic [31:0] y;
        y = (x[30:0] == 31'd0) ? 32'd0 : x;
        return y[31] ? ~y : (y | 32'h8000_0000);
    endfunction

endpackage

// ----- rtl/mie_front.sv -----
// Front end: accepts instruction transfers, classifies them, feeds a two-entry queue.
module mie_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [31:0]         i_ins,
    output logic                o_valid,
    input  logic                i_ready,
    output mie_pkg::t_decoded   o_item
);
    mie_pkg::t_decoded r_q [2];
    logic              r_head;
    logic              r_tail;
    logic [1:0]        r_cnt;
    logic              push, pop;
    logic              supported;
    mie_pkg::t_decoded d;

    always_comb begin
        unique case (i_ins[31:26])
            mie_pkg::OP_BL, mie_pkg::OP_J, mie_pkg::OP_FBNE, mie_pkg::OP_BEQ,
            mie_pkg::OP_BNE, mie_pkg::OP_BG, mie_pkg::OP_FBG, mie_pkg::OP_ADDI,
            mie_pkg::OP_JAL, mie_pkg::OP_LW, mie_pkg::OP_LWS, mie_pkg::OP_SW,
            mie_pkg::OP_SWS, mie_pkg::OP_SLL: supported = 1'b1;
            default: supported = 1'b0;
        endcase
        d.ins       = i_ins;
        d.supported = supported;
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_head];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_tail] <= d;
        end
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_tail <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) r_tail <= ~r_tail;
            if (pop)  r_head <= ~r_head;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ----- rtl/mie_back.sv -----
// Back end: register files, data memory, pc; executes one instruction per cycle when not stalled.
module mie_back #(
    parameter int MEM_ADDR_WIDTH = mie_pkg::MEM_ADDR_WIDTH_DEF,
    parameter int PC_WIDTH       = mie_pkg::PC_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  mie_pkg::t_decoded i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [82:0]       o_data
);
    localparam int MEM_WORDS = 1 << MEM_ADDR_WIDTH;

    // Stage A reads registers and memory; stage B finishes and writes back.
    logic [31:0] r_ireg [32];
    logic [31:0] r_freg [32];
    logic [31:0] r_mem  [MEM_WORDS];
    logic [PC_WIDTH-1:0] r_pc;

    logic [MEM_ADDR_WIDTH:0]   r_clr;
    logic                      clearing;
    assign clearing = !r_clr[MEM_ADDR_WIDTH];

    // stage B registers
    logic        r_bv;
    logic [31:0] r_bins;
    logic        r_bsup;
    logic [31:0] r_ba, r_bb, r_bfa, r_bfb, r_bmem;
    logic [MEM_ADDR_WIDTH-1:0] r_bea;
    logic        r_bfwd;        // memory read hit on the store retiring same cycle
    logic [31:0] r_bfwd_val;

    // output register
    logic        r_ov;
    logic [82:0] r_od;

    logic adv_b, take_a;
    assign adv_b   = r_bv && (!r_ov || i_ready);
    assign take_a  = i_valid && !clearing && (!r_bv || adv_b);
    assign o_ready = take_a;
    assign o_valid = r_ov;
    assign o_data  = r_od;

    // ---- stage B execute ----
    logic [5:0]  op;
    logic [4:0]  rt, rd, sa;
    logic [31:0] off, memv;
    logic [PC_WIDTH-1:0] nxt;
    logic        taken, cond, br, w_i, w_f, w_m;
    logic [1:0]  kind;
    logic [4:0]  idx;
    logic [31:0] val;
    logic [15:0] addr;
    logic [4:0]  widx;
    logic [MEM_ADDR_WIDTH-1:0] ea_b;

    always_comb begin
        op   = r_bins[31:26];
        rt   = r_bins[20:16];
        rd   = r_bins[15:11];
        sa   = r_bins[10:6];
        off  = {{16{r_bins[15]}}, r_bins[15:0]};
        memv = r_bfwd ? r_bfwd_val : r_bmem;
        ea_b = r_bea;
        nxt  = r_pc + PC_WIDTH'(1);
        taken = 1'b0; cond = 1'b0; br = 1'b0;
        kind = mie_pkg::DK_NONE; idx = 5'd0; val = 32'd0; addr = 16'd0;
        w_i = 1'b0; w_f = 1'b0; w_m = 1'b0; widx = 5'd0;
        if (r_bsup) begin
            unique case (op)
                mie_pkg::OP_ADDI: begin
                    val = r_ba + off; kind = mie_pkg::DK_INT; idx = rt; w_i = 1'b1;
                end
                mie_pkg::OP_SLL: begin
                    val = r_bb << sa; kind = mie_pkg::DK_INT; idx = rd; w_i = 1'b1;
                end
                mie_pkg::OP_LW: begin
                    val = memv; kind = mie_pkg::DK_INT; idx = rt; w_i = 1'b1;
                    addr = 16'(ea_b);
                end
                mie_pkg::OP_LWS: begin
                    val = memv; kind = mie_pkg::DK_FLOAT; idx = rt; w_f = 1'b1;
                    addr = 16'(ea_b);
                end
                mie_pkg::OP_SW: begin
                    val = r_bb; kind = mie_pkg::DK_MEM; w_m = 1'b1; addr = 16'(ea_b);
                end
                mie_pkg::OP_SWS: begin
                    val = r_bfb; kind = mie_pkg::DK_MEM; w_m = 1'b1; addr = 16'(ea_b);
                end
                mie_pkg::OP_J: begin
                    nxt = r_bins[PC_WIDTH-1:0]; taken = 1'b1;
                end
                mie_pkg::OP_JAL: begin
                    nxt = r_bins[PC_WIDTH-1:0]; taken = 1'b1;
                    kind = mie_pkg::DK_INT; idx = mie_pkg::LINK_REG; w_i = 1'b1;
                    val = 32'(r_pc);
                end
                mie_pkg::OP_BEQ: begin br = 1'b1; cond = (r_ba == r_bb); end
                mie_pkg::OP_BNE: begin br = 1'b1; cond = (r_ba != r_bb); end
                mie_pkg::OP_BG:  begin br = 1'b1; cond = (r_ba > r_bb); end
                mie_pkg::OP_BL:  begin br = 1'b1; cond = (r_ba < r_bb); end
                mie_pkg::OP_FBG: begin
                    br = 1'b1;
                    cond = !mie_pkg::f_is_nan(r_bfa) && !mie_pkg::f_is_nan(r_bfb)
                        && (mie_pkg::f_key(r_bfa) > mie_pkg::f_key(r_bfb));
                end
                mie_pkg::OP_FBNE: begin
                    br = 1'b1;
                    cond = mie_pkg::f_is_nan(r_bfa) || mie_pkg::f_is_nan(r_bfb)
                        || (mie_pkg::f_key(r_bfa) != mie_pkg::f_key(r_bfb));
                end
                default: ;
            endcase
        end
        if (br && cond) begin
            nxt = r_pc + off[PC_WIDTH-1:0]; taken = 1'b1;
        end
        widx = idx;
    end

    // ---- stage A read with bypass from stage B ----
    logic [4:0]  a_rs, a_rt;
    logic [31:0] a_a, a_b, a_fa, a_fb, a_off;
    logic [MEM_ADDR_WIDTH-1:0] a_ea;
    logic        wb_i, wb_f, wb_m;

    always_comb begin
        a_rs  = i_item.ins[25:21];
        a_rt  = i_item.ins[20:16];
        a_off = {{16{i_item.ins[15]}}, i_item.ins[15:0]};
        wb_i  = adv_b && w_i;
        wb_f  = adv_b && w_f;
        wb_m  = adv_b && w_m;
        a_a   = (wb_i && widx == a_rs) ? val : r_ireg[a_rs];
        a_b   = (wb_i && widx == a_rt) ? val : r_ireg[a_rt];
        a_fa  = (wb_f && widx == a_rs) ? val : r_freg[a_rs];
        a_fb  = (wb_f && widx == a_rt) ? val : r_freg[a_rt];
        a_ea  = MEM_ADDR_WIDTH'(a_a + a_off);
    end

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (clearing) begin
            r_mem[r_clr[MEM_ADDR_WIDTH-1:0]] <= 32'd0;
        end else if (wb_m) begin
            r_mem[ea_b] <= val;
        end
        if (take_a) begin
            r_bmem <= r_mem[a_ea];
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_a) begin
            r_bins     <= i_item.ins;
            r_bsup     <= i_item.supported;
            r_ba       <= a_a;
            r_bb       <= a_b;
            r_bfa      <= a_fa;
            r_bfb      <= a_fb;
            r_bea      <= a_ea;
            r_bfwd     <= wb_m && (ea_b == a_ea);
            r_bfwd_val <= val;
        end
        if (adv_b) begin
            r_od <= {!r_bsup, addr, val, idx, kind, taken, 26'(nxt)};
        end
        if (!i_rst_n) begin
            r_pc  <= '0;
            r_bv  <= 1'b0;
            r_ov  <= 1'b0;
            r_clr <= '0;
            for (int k = 0; k < 32; k++) begin
                r_ireg[k] <= 32'd0;
                r_freg[k] <= 32'd0;
            end
        end else begin
            if (clearing) r_clr <= r_clr + 1'b1;
            if (wb_i) r_ireg[widx] <= val;
            if (wb_f) r_freg[widx] <= val;
            if (adv_b) r_pc <= nxt;
            if (take_a) r_bv <= 1'b1;
            else if (adv_b) r_bv <= 1'b0;
            if (adv_b) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end
endmodule

// ----- rtl/mips_like_instruction_execute.sv -----
// Top level: MIPS-style execute unit, front classifier plus back execution pipe.
// Path: the input transfer enters the front queue, then stage A reads registers and
// memory into the stage B registers, then stage B executes into the output register.
// Throughput: one instruction per cycle if not stalled; pc and bypass add no stall.
// Reset: synchronous active low; clears pc and register files at once, then a
// clearing pass over all 2**MEM_ADDR_WIDTH data memory words (65536 by default) runs,
// during which the back end takes no instruction (the front queue holds up to two).
module mips_like_instruction_execute #(
    parameter int MEM_ADDR_WIDTH = mie_pkg::MEM_ADDR_WIDTH_DEF,
    parameter int PC_WIDTH       = mie_pkg::PC_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // instruction[31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // next_pc[25:0], branch_taken[26], dest_kind[28:27], dest_index[33:29],
    // write_value[65:34], mem_address[81:66], unsupported[82], zero fill above
    output logic [87:0] m_axis_tdata
);
    mie_pkg::t_decoded q_item;
    logic              q_valid, q_ready;
    logic [82:0]       res;

    mie_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_ins   (s_axis_tdata),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    mie_back #(
        .MEM_ADDR_WIDTH (MEM_ADDR_WIDTH),
        .PC_WIDTH       (PC_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (res)
    );

    assign m_axis_tdata = {5'd0, res};
endmodule
